FILE: rtl/vlc_pkg.sv
package vlc_pkg;

  localparam int unsigned MEM_LINE_BYTES_DEF = 64;
  localparam int unsigned REG_LINE_BYTES_DEF = 64;
  localparam int unsigned INDEX_QUEUE_DEPTH_DEF = 64;
  localparam int unsigned MAX_ELEMENTS_DEF = 65536;
  localparam int unsigned RUN_MAX = 64;

  // configuration register indexes
  localparam logic [2:0] REG_BASE   = 3'd0;
  localparam logic [2:0] REG_STRIDE = 3'd1;
  localparam logic [2:0] REG_SIZE   = 3'd2;
  localparam logic [2:0] REG_COUNT  = 3'd3;
  localparam logic [2:0] REG_INDEX  = 3'd4;
  localparam logic [2:0] REG_RFILE  = 3'd5;

  // input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_ISSUE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;     // clear index and queue
    logic push;      // write index into queue
    logic begin_run; // latch limit and port readiness of an attempt
    logic calc;      // compute address of candidate element
    logic check;     // compare candidate line, extend run
    logic emit;      // load output register with one result
    logic commit;    // advance index / pop queue
  } vlc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // nothing to issue
    logic more;      // another candidate remains
    logic hit;       // candidate in same line
    logic emit_last; // current emitted element ends the run
  } vlc_stat_t;

endpackage

FILE: rtl/vlc_datapath.sv
module vlc_datapath #(
  parameter int unsigned MEM_LINE_BYTES = 64,
  parameter int unsigned REG_LINE_BYTES = 64,
  parameter int unsigned INDEX_QUEUE_DEPTH = 64,
  parameter int unsigned MAX_ELEMENTS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  input  logic [63:0]         in_index_value,
  input  logic                in_port_ready,
  input  vlc_pkg::vlc_cmd_t   cmd,
  output vlc_pkg::vlc_stat_t  stat,
  output logic [1:0]          res_status,
  output logic [63:0]         res_line_address,
  output logic [5:0]          res_element_offset,
  output logic [15:0]         res_element_number,
  output logic                res_last_of_vector,
  output logic                res_last_of_run,
  output logic                res_all_done
);
  import vlc_pkg::*;

  localparam int QW = $clog2(INDEX_QUEUE_DEPTH);
  localparam int FW = QW + 1;
  localparam int CW = $clog2(MAX_ELEMENTS) + 1;
  localparam int PW = CW + 33;

  // wrap a queue position back into the ring
  function automatic logic [QW-1:0] ring_pos(input logic [QW:0] p);
    if (p >= (QW+1)'(INDEX_QUEUE_DEPTH)) return QW'(p - (QW+1)'(INDEX_QUEUE_DEPTH));
    return QW'(p);
  endfunction

  // configuration
  logic [63:0] base_r;
  logic [31:0] stride_r;
  logic [1:0]  size_r;
  logic [16:0] count_r;
  logic        indexed_r;
  logic        rfile_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      stride_r <= 32'd1;
      size_r <= '0;
      count_r <= 17'd1;
      indexed_r <= 1'b0;
      rfile_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:   base_r <= cfg_wdata;
        REG_STRIDE: stride_r <= cfg_wdata[31:0];
        REG_SIZE:   size_r <= cfg_wdata[1:0];
        REG_COUNT:  count_r <= cfg_wdata[16:0];
        REG_INDEX:  indexed_r <= cfg_wdata[0];
        REG_RFILE:  rfile_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective count clamped to MAX_ELEMENTS
  logic [CW-1:0] count_eff;
  always_comb begin
    if (count_r > 17'(MAX_ELEMENTS)) count_eff = CW'(MAX_ELEMENTS);
    else count_eff = CW'(count_r);
  end

  logic [6:0] line_bytes;
  logic [63:0] lmask;
  logic [6:0] per_line;
  assign line_bytes = rfile_r ? 7'(REG_LINE_BYTES) : 7'(MEM_LINE_BYTES);
  assign lmask = 64'(line_bytes) - 64'd1;
  always_comb begin
    per_line = line_bytes >> size_r;
    if (per_line == 7'd0) per_line = 7'd1;
  end

  // element index, queue ring head and fill
  logic [CW-1:0] eidx_r;
  logic [FW-1:0] fill_r;
  logic [QW-1:0] head_r;
  logic [63:0]   queue_mem [INDEX_QUEUE_DEPTH];

  // run state
  logic [6:0]    limit_r;
  logic [6:0]    j_r;        // candidate position
  logic [6:0]    n_r;        // run length
  logic [6:0]    e_r;        // emit position
  logic [63:0]   line_r;
  logic [63:0]   cand_r;     // candidate address
  logic [5:0]    offs_r [RUN_MAX];
  logic [63:0]   prod_r;
  logic          ready_r;
  logic [63:0]   qrd_r;

  // limit computation
  logic [CW-1:0] remain;
  logic [6:0]    limit_c;
  always_comb begin
    remain = (eidx_r < count_eff) ? count_eff - eidx_r : '0;
    limit_c = per_line;
    if (32'(remain) < 32'(limit_c)) limit_c = 7'(remain);
    if (indexed_r && (32'(limit_c) > 32'(fill_r))) limit_c = 7'(fill_r);
  end

  // address of element at position j (queue read registered in qrd_r)
  logic [63:0] idx_m;
  logic [63:0] addr_c;
  always_comb begin
    case (size_r)
      2'd0: idx_m = {56'd0, qrd_r[7:0]};
      2'd1: idx_m = {48'd0, qrd_r[15:0]};
      2'd2: idx_m = {32'd0, qrd_r[31:0]};
      default: idx_m = qrd_r;
    endcase
    if (indexed_r) addr_c = base_r + idx_m;
    else addr_c = base_r + (prod_r << size_r);
  end

  // queue read address during runs, write address for pushes
  logic [QW-1:0] qaddr;
  logic [QW-1:0] waddr;
  assign qaddr = ring_pos({1'b0, head_r} + (QW+1)'(j_r));
  assign waddr = ring_pos({1'b0, head_r} + (QW+1)'(fill_r));

  // element position times signed stride
  logic [CW-1:0]        pos;
  logic signed [PW-1:0] prod_s;
  assign pos = eidx_r + CW'(j_r);
  assign prod_s = $signed({1'b0, pos}) * $signed(stride_r);

  always_ff @(posedge clk) begin
    // queue read, and multiply for strided address
    qrd_r <= queue_mem[qaddr];
    prod_r <= 64'(prod_s);
    if (cmd.push && (fill_r < FW'(INDEX_QUEUE_DEPTH)))
      queue_mem[waddr] <= in_index_value;
  end

  // candidate address register
  always_ff @(posedge clk) begin
    if (cmd.calc) cand_r <= addr_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eidx_r <= '0;
      fill_r <= '0;
      head_r <= '0;
      j_r <= '0;
      n_r <= '0;
      e_r <= '0;
      limit_r <= '0;
      ready_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        eidx_r <= '0;
        fill_r <= '0;
        head_r <= '0;
      end
      if (cmd.push && (fill_r < FW'(INDEX_QUEUE_DEPTH))) fill_r <= fill_r + FW'(1);
      if (cmd.begin_run) begin
        limit_r <= limit_c;
        j_r <= '0;
        n_r <= '0;
        e_r <= '0;
        ready_r <= in_port_ready;
      end
      if (cmd.check) begin
        if (n_r == 7'd0) begin
          line_r <= cand_r & ~lmask;
          offs_r[0] <= 6'(cand_r & lmask);
          n_r <= 7'd1;
        end else if ((cand_r & ~lmask) == line_r) begin
          offs_r[6'(n_r)] <= 6'(cand_r & lmask);
          n_r <= n_r + 7'd1;
        end
        j_r <= j_r + 7'd1;
      end
      if (cmd.emit && !stat.empty) e_r <= e_r + 7'd1;
      // advance index and drop the used indices from the ring
      if (cmd.commit && ready_r) begin
        eidx_r <= eidx_r + CW'(n_r);
        if (indexed_r) begin
          head_r <= ring_pos({1'b0, head_r} + (QW+1)'(n_r));
          fill_r <= fill_r - FW'(n_r);
        end
      end
    end
  end

  assign stat.empty = (limit_r == 7'd0);
  assign stat.more = (j_r < limit_r);
  assign stat.hit = (n_r == 7'd0) || ((cand_r & ~lmask) == line_r);
  assign stat.emit_last = stat.empty || (e_r + 7'd1 == n_r);

  // result register
  logic [CW-1:0] num_c;
  logic [CW-1:0] idx_after;
  assign num_c = eidx_r + CW'(e_r);
  assign idx_after = ready_r ? eidx_r + CW'(n_r) : eidx_r;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (stat.empty) begin
        res_status <= ST_NONE;
        res_line_address <= '0;
        res_element_offset <= '0;
        res_element_number <= '0;
        res_last_of_vector <= 1'b0;
        res_last_of_run <= 1'b1;
        res_all_done <= (eidx_r >= count_eff);
      end else begin
        res_status <= ready_r ? ST_ACCEPT : ST_REFUSED;
        res_line_address <= line_r;
        res_element_offset <= offs_r[6'(e_r)];
        res_element_number <= 16'(num_c);
        res_last_of_vector <= (num_c + CW'(1)) == count_eff;
        res_last_of_run <= (e_r + 7'd1 == n_r);
        res_all_done <= (idx_after >= count_eff);
      end
    end
  end
endmodule

FILE: rtl/vlc_ctrl.sv
module vlc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  output logic               out_valid,
  input  logic               out_stall,
  output vlc_pkg::vlc_cmd_t  cmd,
  input  vlc_pkg::vlc_stat_t stat
);
  import vlc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_START: cmd.start = 1'b1;
            CMD_PUSH:  cmd.push = 1'b1;
            CMD_ISSUE: begin
              // latch limit and port readiness with the transfer
              cmd.begin_run = 1'b1;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // queue read and multiply for candidate j
        if (stat.empty || !stat.more) state_nxt = S_EMIT;
        else state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.hit) begin
          cmd.check = 1'b1;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // one result per transfer slot
        if (!ov_r || !out_stall) begin
          cmd.emit = 1'b1;
          ov_nxt = 1'b1;
          if (stat.emit_last) state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // commit once the final result has left
        if (!ov_nxt) begin
          cmd.commit = !stat.empty;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

FILE: rtl/vector_load_line_coalescer_unit.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | command, index_value, port_ready
// out     | output    | out_valid/out_stall| status, line_address, offsets, flags
// cfg     | input     | cfg_we             | cfg_index, cfg_wdata
// An issue attempt passes, for each examined element, through queue read and multiply,
// address and line compare, with one more queue read when the run stops at its limit;
// it then emits one result per transfer slot and retires once the last has left.
// Reset is synchronous, active low.
// out_stall holds the result register; input is stalled while an attempt runs.
module vector_load_line_coalescer_unit #(
  parameter int unsigned MEM_LINE_BYTES = vlc_pkg::MEM_LINE_BYTES_DEF,
  parameter int unsigned REG_LINE_BYTES = vlc_pkg::REG_LINE_BYTES_DEF,
  parameter int unsigned INDEX_QUEUE_DEPTH = vlc_pkg::INDEX_QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_ELEMENTS = vlc_pkg::MAX_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_index_value,
  input  logic        in_port_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_line_address,
  output logic [5:0]  out_element_offset,
  output logic [15:0] out_element_number,
  output logic        out_last_of_vector,
  output logic        out_last_of_run,
  output logic        out_all_done
);
  import vlc_pkg::*;

  vlc_cmd_t  cmd;
  vlc_stat_t stat;

  vlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat)
  );

  vlc_datapath #(
    .MEM_LINE_BYTES(MEM_LINE_BYTES), .REG_LINE_BYTES(REG_LINE_BYTES),
    .INDEX_QUEUE_DEPTH(INDEX_QUEUE_DEPTH), .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_index_value(in_index_value),
    .in_port_ready(in_port_ready), .cmd(cmd), .stat(stat),
    .res_status(out_status), .res_line_address(out_line_address),
    .res_element_offset(out_element_offset),
    .res_element_number(out_element_number),
    .res_last_of_vector(out_last_of_vector),
    .res_last_of_run(out_last_of_run), .res_all_done(out_all_done)
  );
endmodule
